[sv/assert_macros.svh]
// Assertion macros shared by the media service kind descriptor parser RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define MSK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true outside reset.
`define MSK_ASSERT_NEVER(label, expr, msg) \
   `MSK_ASSERT(label, !(expr), msg)

`endif

[sv/msk_pkg.sv]
// Types, constants and parse helper functions for the media service kind
// descriptor parser. No dependencies.
`timescale 1ns / 1ps

package msk_pkg;

   localparam int ID_TYPE_W = 13;

   typedef enum logic [3:0] {
      PH_KIND       = 4'd0,
      PH_ID_HI      = 4'd1,
      PH_ID_LO      = 4'd2,
      PH_ID_LEN     = 4'd3,
      PH_ID_BYTES   = 4'd4,
      PH_PAIR       = 4'd5,
      PH_LANG_LEN   = 4'd6,
      PH_LANG_BYTES = 4'd7,
      PH_PURPOSE    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      EL_KIND_HDR  = 3'd0,
      EL_ID_HDR    = 3'd1,
      EL_ID_LEN    = 3'd2,
      EL_ID_BYTE   = 3'd3,
      EL_PAIR_HDR  = 3'd4,
      EL_LANG_LEN  = 3'd5,
      EL_LANG_BYTE = 3'd6,
      EL_PURPOSE   = 3'd7
   } element_type;

   localparam logic [2:0] ID_LEN_EXPLICIT   = 3'd7;
   localparam logic [1:0] LANG_LEN_EXPLICIT = 2'd0;

   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       last_byte;
   } in_item_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] pairs_left;
      logic [2:0] purposes_left;
      logic [7:0] bytes_left;
      logic [7:0] held_header_byte;
      logic [7:0] kind_counter;
      logic [2:0] pair_counter;
   } state_type;

   typedef struct packed {
      element_type          element_kind;
      logic                 description_flag;
      logic                 has_identifier;
      logic [2:0]           entry_count;
      logic [1:0]           type_code;
      logic [2:0]           length_code;
      logic [ID_TYPE_W-1:0] identifier_type;
      logic [7:0]           resolved_length;
      logic [7:0]           data_value;
      logic [7:0]           kind_number;
      logic [2:0]           pair_number;
      logic                 truncated;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:            PH_KIND,
      pairs_left:       3'd0,
      purposes_left:    3'd0,
      bytes_left:       8'd0,
      held_header_byte: 8'd0,
      kind_counter:     8'd0,
      pair_counter:     3'd0
   };

   function automatic logic [7:0] id_length(input logic [2:0] code);
      logic [7:0] len;
      case (code)
         3'd0:    len = 8'd1;
         3'd1:    len = 8'd2;
         3'd2:    len = 8'd4;
         3'd3:    len = 8'd8;
         3'd4:    len = 8'd12;
         3'd5:    len = 8'd16;
         3'd6:    len = 8'd20;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] lang_length(input logic [1:0] idx);
      logic [7:0] len;
      case (idx)
         2'd1:    len = 8'd2;
         2'd2:    len = 8'd3;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

   function automatic state_type finish_kind(input state_type s);
      state_type t;
      t               = s;
      t.phase         = PH_KIND;
      t.kind_counter  = s.kind_counter + 8'd1;
      t.pair_counter  = 3'd0;
      t.pairs_left    = 3'd0;
      t.purposes_left = 3'd0;
      t.bytes_left    = 8'd0;
      return t;
   endfunction

   function automatic state_type next_pair_or_end(input state_type s);
      state_type t;
      t = s;
      if (s.pairs_left != 3'd0) begin
         t.phase = PH_PAIR;
      end else begin
         t = finish_kind(s);
      end
      return t;
   endfunction

   function automatic state_type end_pair(input state_type s);
      state_type t;
      t              = s;
      t.pairs_left   = s.pairs_left - 3'd1;
      t.pair_counter = s.pair_counter + 3'd1;
      return next_pair_or_end(t);
   endfunction

   function automatic state_type after_lang(input state_type s);
      state_type t;
      t = s;
      if (s.purposes_left != 3'd0) begin
         t.phase = PH_PURPOSE;
      end else begin
         t = end_pair(s);
      end
      return t;
   endfunction

   function automatic state_type after_lang_len(input state_type s);
      state_type t;
      t = s;
      if (s.bytes_left != 8'd0) begin
         t.phase = PH_LANG_BYTES;
      end else begin
         t = after_lang(s);
      end
      return t;
   endfunction

endpackage

[sv/media_service_kind_descriptor_parser.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   payload_byte, last_byte
// rsp       out        rsp_valid/rsp_stall   at most one decoded element per request
//
// Takes one request per cycle while req_stall is low; a byte passes the input register, then the result register.
// The decode between the input and result registers is combinational.
// The first ID header byte gives no result unless it ends the payload.
// Reset is synchronous and returns the parser to the kind header phase.
// A stalled result holds the result register; the input register fills behind it.
// Depends on msk_pkg, msk_input_stage, msk_parser and msk_output_stage.
`timescale 1ns / 1ps

module media_service_kind_descriptor_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_payload_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_element_kind,
   output logic                           rsp_description_flag,
   output logic                           rsp_has_identifier,
   output logic [2:0]                     rsp_entry_count,
   output logic [1:0]                     rsp_type_code,
   output logic [2:0]                     rsp_length_code,
   output logic [msk_pkg::ID_TYPE_W-1:0]  rsp_identifier_type,
   output logic [7:0]                     rsp_resolved_length,
   output logic [7:0]                     rsp_data_value,
   output logic [7:0]                     rsp_kind_number,
   output logic [2:0]                     rsp_pair_number,
   output logic                           rsp_truncated
);
   import msk_pkg::*;

   in_item_type item;
   result_type  result;
   result_type  rsp_result;
   logic        advance;
   logic        emit;

   msk_input_stage u_input (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload_byte (req_payload_byte),
      .req_last_byte    (req_last_byte),
      .advance          (advance),
      .item             (item)
   );

   msk_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .emit    (emit),
      .result  (result)
   );

   msk_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (item.valid),
      .emit       (emit),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_element_kind     = rsp_result.element_kind;
   assign rsp_description_flag = rsp_result.description_flag;
   assign rsp_has_identifier   = rsp_result.has_identifier;
   assign rsp_entry_count      = rsp_result.entry_count;
   assign rsp_type_code        = rsp_result.type_code;
   assign rsp_length_code      = rsp_result.length_code;
   assign rsp_identifier_type  = rsp_result.identifier_type;
   assign rsp_resolved_length  = rsp_result.resolved_length;
   assign rsp_data_value       = rsp_result.data_value;
   assign rsp_kind_number      = rsp_result.kind_number;
   assign rsp_pair_number      = rsp_result.pair_number;
   assign rsp_truncated        = rsp_result.truncated;

endmodule

[sv/msk_input_stage.sv]
// Input register of the descriptor parser: holds one accepted request byte.
// Depends on msk_pkg.
`timescale 1ns / 1ps

module msk_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_payload_byte,
   input  logic                req_last_byte,
   input  logic                advance,
   output msk_pkg::in_item_type item
);
   import msk_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_payload_byte;
         last_ff <= req_last_byte;
      end
   end

   assign item = '{valid: valid_ff, payload_byte: byte_ff, last_byte: last_ff};

endmodule

[sv/msk_parser.sv]
// Parse state registers and the per-byte decode logic of the descriptor
// parser. Depends on msk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msk_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  msk_pkg::in_item_type item,
   input  logic                 advance,
   output logic                 emit,
   output msk_pkg::result_type  result
);
   import msk_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type nxt;
   logic      step_en;
   logic [7:0] b;
   logic [2:0] code;

   assign step_en = item.valid && advance;
   assign b       = item.payload_byte;
   assign code    = state_ff.held_header_byte[7:5];

   always_comb begin
      nxt                = state_ff;
      result             = '0;
      result.kind_number = state_ff.kind_counter;
      emit               = 1'b1;
      unique case (state_ff.phase)
         PH_ID_HI: begin
            nxt.held_header_byte = b;
            nxt.phase            = PH_ID_LO;
            if (item.last_byte) begin
               result.element_kind    = EL_ID_HDR;
               result.length_code     = b[7:5];
               result.identifier_type = {b[4:0], 8'd0};
            end else begin
               emit = 1'b0;
            end
         end
         PH_ID_LO: begin
            result.element_kind    = EL_ID_HDR;
            result.length_code     = code;
            result.identifier_type = {state_ff.held_header_byte[4:0], b};
            if (code == ID_LEN_EXPLICIT) begin
               nxt.phase = PH_ID_LEN;
            end else begin
               nxt.bytes_left         = id_length(code);
               result.resolved_length = id_length(code);
               nxt.phase              = PH_ID_BYTES;
            end
         end
         PH_ID_LEN: begin
            result.element_kind    = EL_ID_LEN;
            result.resolved_length = b;
            nxt.bytes_left         = b;
            if (b != 8'd0) begin
               nxt.phase = PH_ID_BYTES;
            end else begin
               nxt = next_pair_or_end(nxt);
            end
         end
         PH_ID_BYTES: begin
            result.element_kind = EL_ID_BYTE;
            result.data_value   = b;
            nxt.bytes_left      = state_ff.bytes_left - 8'd1;
            if (nxt.bytes_left == 8'd0) begin
               nxt = next_pair_or_end(nxt);
            end
         end
         PH_PAIR: begin
            result.element_kind = EL_PAIR_HDR;
            result.entry_count  = b[5:3];
            result.type_code    = b[7:6];
            result.length_code  = {1'b0, b[2:1]};
            result.pair_number  = state_ff.pair_counter;
            nxt.purposes_left   = b[5:3];
            if (b[2:1] == LANG_LEN_EXPLICIT) begin
               nxt.phase = PH_LANG_LEN;
            end else begin
               nxt.bytes_left         = lang_length(b[2:1]);
               result.resolved_length = lang_length(b[2:1]);
               nxt                    = after_lang_len(nxt);
            end
         end
         PH_LANG_LEN: begin
            result.element_kind    = EL_LANG_LEN;
            result.resolved_length = b;
            result.pair_number     = state_ff.pair_counter;
            nxt.bytes_left         = b;
            nxt                    = after_lang_len(nxt);
         end
         PH_LANG_BYTES: begin
            result.element_kind = EL_LANG_BYTE;
            result.data_value   = b;
            result.pair_number  = state_ff.pair_counter;
            nxt.bytes_left      = state_ff.bytes_left - 8'd1;
            if (nxt.bytes_left == 8'd0) begin
               nxt = after_lang(nxt);
            end
         end
         PH_PURPOSE: begin
            result.element_kind = EL_PURPOSE;
            result.data_value   = b;
            result.pair_number  = state_ff.pair_counter;
            nxt.purposes_left   = state_ff.purposes_left - 3'd1;
            if (nxt.purposes_left == 3'd0) begin
               nxt = end_pair(nxt);
            end
         end
         default: begin
            result.element_kind     = EL_KIND_HDR;
            result.description_flag = b[7];
            result.has_identifier   = b[6];
            result.entry_count      = b[5:3];
            result.type_code        = b[2:1];
            nxt.pairs_left          = b[5:3];
            nxt.pair_counter        = 3'd0;
            if (b[6]) begin
               nxt.phase = PH_ID_HI;
            end else begin
               nxt = next_pair_or_end(nxt);
            end
         end
      endcase
      if (item.last_byte) begin
         result.truncated = (nxt.phase != PH_KIND);
         nxt              = STATE_RESET;
      end
      state_in = step_en ? nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   `MSK_ASSERT(a_kind_phase_clean, (state_ff.phase == PH_KIND) |-> (state_ff.pairs_left == 3'd0 && state_ff.purposes_left == 3'd0 && state_ff.bytes_left == 8'd0 && state_ff.pair_counter == 3'd0), "Kind header phase with leftover entry state")
   `MSK_ASSERT_NEVER(a_empty_byte_run, ((state_ff.phase == PH_ID_BYTES || state_ff.phase == PH_LANG_BYTES) && state_ff.bytes_left == 8'd0) || (state_ff.phase == PH_PURPOSE && state_ff.purposes_left == 3'd0), "Data phase entered with nothing left to read")
   `MSK_ASSERT(a_last_restarts, (step_en && item.last_byte) |=> (state_ff.phase == PH_KIND && state_ff.kind_counter == 8'd0), "Final payload byte did not restart the parser")

endmodule

[sv/msk_output_stage.sv]
// Result register of the descriptor parser with its valid/stall handshake.
// Depends on msk_pkg.
`timescale 1ns / 1ps

module msk_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                emit,
   input  msk_pkg::result_type result,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output msk_pkg::result_type rsp_result
);
   import msk_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic       load;
   result_type result_ff;

   assign advance  = !valid_ff || !rsp_stall;
   assign load     = in_valid && advance && emit;
   assign valid_in = advance ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

[test/tb.sv]
// Self-checking testbench for media_service_kind_descriptor_parser: sends descriptor payload
// bytes with random gaps and back-pressure and checks every decoded element against a predictor.
// Depends on msk_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb;
   import msk_pkg::*;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_payload_byte = 8'h00;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_element_kind;
   logic                 rsp_description_flag;
   logic                 rsp_has_identifier;
   logic [2:0]           rsp_entry_count;
   logic [1:0]           rsp_type_code;
   logic [2:0]           rsp_length_code;
   logic [ID_TYPE_W-1:0] rsp_identifier_type;
   logic [7:0]           rsp_resolved_length;
   logic [7:0]           rsp_data_value;
   logic [7:0]           rsp_kind_number;
   logic [2:0]           rsp_pair_number;
   logic                 rsp_truncated;

   int         send_gap_max = 14;
   int         rsp_gap_max = 14;
   bit         long_hold = 1'b0;
   int         mismatches = 0;
   int         sent_count = 0;
   result_type expected_elements[$];
   logic [7:0] descriptor_bytes[$];

   phase_type  parse_phase;
   logic [2:0] pairs_to_go;
   logic [2:0] purposes_to_go;
   logic [2:0] pair_index;
   logic [7:0] bytes_to_go;
   logic [7:0] id_high_byte;
   logic [7:0] kind_index;

   media_service_kind_descriptor_parser DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_payload_byte     (req_payload_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_element_kind     (rsp_element_kind),
      .rsp_description_flag (rsp_description_flag),
      .rsp_has_identifier   (rsp_has_identifier),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_type_code        (rsp_type_code),
      .rsp_length_code      (rsp_length_code),
      .rsp_identifier_type  (rsp_identifier_type),
      .rsp_resolved_length  (rsp_resolved_length),
      .rsp_data_value       (rsp_data_value),
      .rsp_kind_number      (rsp_kind_number),
      .rsp_pair_number      (rsp_pair_number),
      .rsp_truncated        (rsp_truncated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] id_byte_count(input logic [2:0] code);
      case (code)
         3'd0:    return 8'd1;
         3'd1:    return 8'd2;
         3'd2:    return 8'd4;
         3'd3:    return 8'd8;
         3'd4:    return 8'd12;
         3'd5:    return 8'd16;
         3'd6:    return 8'd20;
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] lang_byte_count(input logic [1:0] idx);
      case (idx)
         2'd1:    return 8'd2;
         2'd2:    return 8'd3;
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] pick_length();
      logic [31:0] w;
      w = $urandom;
      if (w[4:0] == 5'd0) begin
         return 8'hFF;
      end else if (w[3:0] == 4'd1) begin
         return w[15:8];
      end
      return {6'd0, w[9:8]};
   endfunction

   task automatic add_byte(input logic [7:0] value);
      descriptor_bytes.insert(descriptor_bytes.size(), value);
   endtask

   task clear_parse_state();
      parse_phase    = PH_KIND;
      pairs_to_go    = 3'd0;
      purposes_to_go = 3'd0;
      bytes_to_go    = 8'd0;
      id_high_byte   = 8'd0;
      kind_index     = 8'd0;
      pair_index     = 3'd0;
   endtask

   task next_pair_or_close();
      if (pairs_to_go != 3'd0) begin
         parse_phase = PH_PAIR;
      end else begin
         parse_phase    = PH_KIND;
         kind_index     = kind_index + 8'd1;
         pair_index     = 3'd0;
         purposes_to_go = 3'd0;
         bytes_to_go    = 8'd0;
      end
   endtask

   task close_pair();
      pairs_to_go = pairs_to_go - 3'd1;
      pair_index  = pair_index + 3'd1;
      next_pair_or_close();
   endtask

   task after_language();
      if (purposes_to_go != 3'd0) begin
         parse_phase = PH_PURPOSE;
      end else begin
         close_pair();
      end
   endtask

   task after_lang_length();
      if (bytes_to_go != 8'd0) begin
         parse_phase = PH_LANG_BYTES;
      end else begin
         after_language();
      end
   endtask

   task automatic predict_element(input logic [7:0] value, input logic last);
      result_type elem;
      logic       emit;
      elem = '0;
      emit = 1'b1;
      elem.kind_number = kind_index;
      case (parse_phase)
         PH_ID_HI: begin
            id_high_byte = value;
            parse_phase  = PH_ID_LO;
            if (last) begin
               elem.element_kind    = EL_ID_HDR;
               elem.length_code     = value[7:5];
               elem.identifier_type = {value[4:0], 8'h00};
            end else begin
               emit = 1'b0;
            end
         end
         PH_ID_LO: begin
            elem.element_kind    = EL_ID_HDR;
            elem.length_code     = id_high_byte[7:5];
            elem.identifier_type = {id_high_byte[4:0], value};
            if (id_high_byte[7:5] == ID_LEN_EXPLICIT) begin
               parse_phase = PH_ID_LEN;
            end else begin
               bytes_to_go          = id_byte_count(id_high_byte[7:5]);
               elem.resolved_length = bytes_to_go;
               parse_phase          = PH_ID_BYTES;
            end
         end
         PH_ID_LEN: begin
            elem.element_kind    = EL_ID_LEN;
            elem.resolved_length = value;
            bytes_to_go          = value;
            if (bytes_to_go != 8'd0) begin
               parse_phase = PH_ID_BYTES;
            end else begin
               next_pair_or_close();
            end
         end
         PH_ID_BYTES: begin
            elem.element_kind = EL_ID_BYTE;
            elem.data_value   = value;
            bytes_to_go       = bytes_to_go - 8'd1;
            if (bytes_to_go == 8'd0) begin
               next_pair_or_close();
            end
         end
         PH_PAIR: begin
            elem.element_kind = EL_PAIR_HDR;
            elem.entry_count  = value[5:3];
            elem.type_code    = value[7:6];
            elem.length_code  = {1'b0, value[2:1]};
            elem.pair_number  = pair_index;
            purposes_to_go    = value[5:3];
            if (value[2:1] == LANG_LEN_EXPLICIT) begin
               parse_phase = PH_LANG_LEN;
            end else begin
               bytes_to_go          = lang_byte_count(value[2:1]);
               elem.resolved_length = bytes_to_go;
               after_lang_length();
            end
         end
         PH_LANG_LEN: begin
            elem.element_kind    = EL_LANG_LEN;
            elem.resolved_length = value;
            elem.pair_number     = pair_index;
            bytes_to_go          = value;
            after_lang_length();
         end
         PH_LANG_BYTES: begin
            elem.element_kind = EL_LANG_BYTE;
            elem.data_value   = value;
            elem.pair_number  = pair_index;
            bytes_to_go       = bytes_to_go - 8'd1;
            if (bytes_to_go == 8'd0) begin
               after_language();
            end
         end
         PH_PURPOSE: begin
            elem.element_kind = EL_PURPOSE;
            elem.data_value   = value;
            elem.pair_number  = pair_index;
            purposes_to_go    = purposes_to_go - 3'd1;
            if (purposes_to_go == 3'd0) begin
               close_pair();
            end
         end
         default: begin
            elem.element_kind     = EL_KIND_HDR;
            elem.description_flag = value[7];
            elem.has_identifier   = value[6];
            elem.entry_count      = value[5:3];
            elem.type_code        = value[2:1];
            pairs_to_go           = value[5:3];
            pair_index            = 3'd0;
            if (value[6]) begin
               parse_phase = PH_ID_HI;
            end else begin
               next_pair_or_close();
            end
         end
      endcase
      if (last) begin
         elem.truncated = (parse_phase != PH_KIND);
         clear_parse_state();
      end
      if (emit) begin
         expected_elements.insert(expected_elements.size(), elem);
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= value;
      req_last_byte    <= last;
      predict_element(value, last);
      sent_count++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_descriptor(input int cut);
      int i;
      for (i = 0; i < cut; i++) begin
         send_byte(descriptor_bytes[i], i == cut - 1);
      end
   endtask

   task automatic build_descriptor();
      int          entries;
      int          count;
      logic [31:0] w;
      logic [31:0] id_word;
      logic [2:0]  pairs;
      logic [7:0]  len;
      descriptor_bytes.delete();
      entries = $urandom_range(1, 3);
      repeat (entries) begin
         w = $urandom;
         pairs = (w[31:29] == 3'd0) ? w[28:26] : {1'b0, w[25] & w[24], w[23]};
         add_byte({w[7:6], pairs, w[2:0]});
         if (w[6]) begin
            id_word = $urandom;
            add_byte(id_word[7:0]);
            add_byte(id_word[15:8]);
            if (id_word[7:5] == ID_LEN_EXPLICIT) begin
               len = pick_length();
               add_byte(len);
            end else begin
               len = id_byte_count(id_word[7:5]);
            end
            count = int'(len);
            repeat (count) begin
               w = $urandom;
               add_byte(w[7:0]);
            end
         end
         repeat (pairs) begin
            id_word = $urandom;
            add_byte(id_word[7:0]);
            if (id_word[2:1] == LANG_LEN_EXPLICIT) begin
               len = pick_length();
               add_byte(len);
            end else begin
               len = lang_byte_count(id_word[2:1]);
            end
            count = int'(len) + int'(id_word[5:3]);
            repeat (count) begin
               w = $urandom;
               add_byte(w[7:0]);
            end
         end
      end
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_elements.size() == 0) begin
            $display("%0t: unexpected result, expected none actual kind %0d", $time,
                     rsp_element_kind);
            mismatches++;
         end else begin
            want = expected_elements.pop_front();
            compare_field("element_kind", want.element_kind, rsp_element_kind);
            compare_field("description_flag", want.description_flag, rsp_description_flag);
            compare_field("has_identifier", want.has_identifier, rsp_has_identifier);
            compare_field("entry_count", want.entry_count, rsp_entry_count);
            compare_field("type_code", want.type_code, rsp_type_code);
            compare_field("length_code", want.length_code, rsp_length_code);
            compare_field("identifier_type", want.identifier_type, rsp_identifier_type);
            compare_field("resolved_length", want.resolved_length, rsp_resolved_length);
            compare_field("data_value", want.data_value, rsp_data_value);
            compare_field("kind_number", want.kind_number, rsp_kind_number);
            compare_field("pair_number", want.pair_number, rsp_pair_number);
            compare_field("truncated", want.truncated, rsp_truncated);
         end
      end
   end

   initial begin : drive_rsp_stall
      int wait_cycles;
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_cycles = $urandom_range(0, rsp_gap_max);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic test_directed();
      send_gap_max = 14;
      rsp_gap_max  = 14;
      send_byte(8'h01, 1'b1);
      send_byte(8'hC6, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h48, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'hCF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h10, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h40, 1'b0);
      send_byte(8'hE5, 1'b1);
      send_byte(8'h08, 1'b0);
      send_byte(8'h04, 1'b0);
      send_byte(8'h61, 1'b1);
   endtask

   task automatic test_kind_counter_wrap();
      logic [31:0] w;
      send_gap_max = 0;
      rsp_gap_max  = 0;
      descriptor_bytes.delete();
      repeat (260) begin
         w = $urandom;
         add_byte({w[7], 4'b0000, w[2:0]});
      end
      send_descriptor(descriptor_bytes.size());
   endtask

   task automatic test_backpressure();
      int start;
      start        = sent_count;
      send_gap_max = 0;
      rsp_gap_max  = 0;
      long_hold    = 1'b1;
      while (sent_count - start < 60) begin
         build_descriptor();
         send_descriptor(descriptor_bytes.size());
      end
   endtask

   task automatic test_random_descriptors();
      int          start;
      int          pick;
      int          cut;
      int          i;
      logic [31:0] w;
      start = sent_count;
      while (sent_count - start < 900) begin
         send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
         rsp_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 14;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            cut = $urandom_range(1, 8);
            for (i = 0; i < cut; i++) begin
               w = $urandom;
               send_byte(w[7:0], (i == cut - 1) || (w[10:8] == 3'd0));
            end
         end else begin
            build_descriptor();
            if (pick == 1) begin
               cut = $urandom_range(1, descriptor_bytes.size());
            end else begin
               cut = descriptor_bytes.size();
            end
            send_descriptor(cut);
         end
      end
   endtask

   initial begin
      clear_parse_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_kind_counter_wrap();
      test_backpressure();
      test_random_descriptors();
      req_valid <= 1'b0;
      while (expected_elements.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
